// ===== hdl/r2fft_pkg.sv =====
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared types, constants and the twiddle table for the radix-2 FFT.
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int POINTS       = 128;
  localparam int TWIDDLE_BITS = 18;
  localparam int FRAC_BITS    = TWIDDLE_BITS - 1;
  localparam int ADDR_BITS    = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int STAGES       = $clog2(POINTS);
  localparam int STAGE_BITS   = (STAGES > 1) ? $clog2(STAGES + 1) : 1;
  localparam int PAIR_BITS    = (ADDR_BITS > 1) ? ADDR_BITS - 1 : 1;
  localparam int DATA_BITS    = 24;
  localparam int SAMPLE_BITS  = 16;
  localparam int OUT_PAIR_BITS = 6;
  localparam int STORE_BITS   = 2 * DATA_BITS;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD,
    ST_MUL,
    ST_WR,
    ST_OUT_RD,
    ST_OUT_HOLD
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic                 load_we;
    logic [ADDR_BITS-1:0] load_addr;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_a;
    logic [ADDR_BITS-1:0] rd_b;
    logic [6:0]           tw_idx;
    logic                 mul_en;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_a;
    logic [ADDR_BITS-1:0] wr_b;
  } cmd_t;

  // quarter-wave cosine, units of 1e-9
  function automatic logic [29:0] cos_e9(input logic [5:0] k);
    unique case (k)
      6'd0:  cos_e9 = 30'd1000000000; 6'd1:  cos_e9 = 30'd998795456;
      6'd2:  cos_e9 = 30'd995184727;  6'd3:  cos_e9 = 30'd989176510;
      6'd4:  cos_e9 = 30'd980785280;  6'd5:  cos_e9 = 30'd970031253;
      6'd6:  cos_e9 = 30'd956940336;  6'd7:  cos_e9 = 30'd941544065;
      6'd8:  cos_e9 = 30'd923879533;  6'd9:  cos_e9 = 30'd903989293;
      6'd10: cos_e9 = 30'd881921264;  6'd11: cos_e9 = 30'd857728610;
      6'd12: cos_e9 = 30'd831469612;  6'd13: cos_e9 = 30'd803207531;
      6'd14: cos_e9 = 30'd773010453;  6'd15: cos_e9 = 30'd740951125;
      6'd16: cos_e9 = 30'd707106781;  6'd17: cos_e9 = 30'd671558955;
      6'd18: cos_e9 = 30'd634393284;  6'd19: cos_e9 = 30'd595699304;
      6'd20: cos_e9 = 30'd555570233;  6'd21: cos_e9 = 30'd514102744;
      6'd22: cos_e9 = 30'd471396737;  6'd23: cos_e9 = 30'd427555093;
      6'd24: cos_e9 = 30'd382683432;  6'd25: cos_e9 = 30'd336889853;
      6'd26: cos_e9 = 30'd290284677;  6'd27: cos_e9 = 30'd242980180;
      6'd28: cos_e9 = 30'd195090322;  6'd29: cos_e9 = 30'd146730474;
      6'd30: cos_e9 = 30'd98017140;   6'd31: cos_e9 = 30'd49067674;
      default: cos_e9 = 30'd0;
    endcase
  endfunction

  // round-half-up(c * 2^F) for all 33 entries, evaluated at elaboration
  function automatic logic [33*TWIDDLE_BITS-1:0] build_rom();
    logic [33*TWIDDLE_BITS-1:0] r;
    logic [63:0]                c;
    r = '0;
    for (int k = 0; k < 33; k++) begin
      c = 64'(cos_e9(6'(k)));
      r[k*TWIDDLE_BITS +: TWIDDLE_BITS] =
        TWIDDLE_BITS'(((c << FRAC_BITS) + 64'd500000000) / 64'd1000000000);
    end
    return r;
  endfunction

  localparam logic [33*TWIDDLE_BITS-1:0] TW_ROM = build_rom();

  function automatic logic [TWIDDLE_BITS-1:0] rom_value(input logic [5:0] k);
    rom_value = TW_ROM[32'(k)*TWIDDLE_BITS +: TWIDDLE_BITS];
  endfunction

  // twiddle exp(-2*pi*i*a/128): {wr, wi}
  function automatic logic [2*TWIDDLE_BITS-1:0] twiddle(input logic [6:0] a_in);
    logic [5:0]                     a;
    logic signed [TWIDDLE_BITS:0]   c;
    logic signed [TWIDDLE_BITS:0]   s;
    logic signed [TWIDDLE_BITS:0]   maxv;
    a    = a_in[5:0];
    maxv = (TWIDDLE_BITS+1)'((1 << FRAC_BITS) - 1);
    if (a <= 6'd32) begin
      c = $signed({1'b0, rom_value(a)});
      s = $signed({1'b0, rom_value(6'd32 - a)});
    end else begin
      c = -$signed({1'b0, rom_value(6'(7'd64 - 7'(a)))});
      s = $signed({1'b0, rom_value(a - 6'd32)});
    end
    if (c > maxv) c = maxv;
    s = -s;
    twiddle = {c[TWIDDLE_BITS-1:0], s[TWIDDLE_BITS-1:0]};
  endfunction

  function automatic logic [ADDR_BITS-1:0] bit_rev(input logic [ADDR_BITS-1:0] v);
    for (int i = 0; i < ADDR_BITS; i++) bit_rev[i] = v[ADDR_BITS-1-i];
  endfunction

endpackage

// ===== hdl/r2fft_ram.sv =====
// ----------------------------------------------------------------------------
// r2fft_ram
// Generic single-write, dual-read RAM with registered read data.
// ----------------------------------------------------------------------------
module r2fft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

// ===== hdl/r2fft_datapath.sv =====
// ----------------------------------------------------------------------------
// r2fft_datapath
// Sample store, butterfly unit with one complex multiplier, output muxes.
// ----------------------------------------------------------------------------
module r2fft_datapath (
  input  logic                                   clk,
  input  r2fft_pkg::cmd_t                        cmd,
  input  logic signed [r2fft_pkg::SAMPLE_BITS-1:0] sample,
  output logic signed [r2fft_pkg::DATA_BITS-1:0] even_real,
  output logic signed [r2fft_pkg::DATA_BITS-1:0] even_imag,
  output logic signed [r2fft_pkg::DATA_BITS-1:0] odd_real,
  output logic signed [r2fft_pkg::DATA_BITS-1:0] odd_imag
);
  localparam int D  = r2fft_pkg::DATA_BITS;
  localparam int TB = r2fft_pkg::TWIDDLE_BITS;
  localparam int PB = D + TB + 1;
  localparam int POINTS_L = r2fft_pkg::POINTS;

  // store word is {real, imag}; two RAM copies give the two writes a butterfly needs
  logic [r2fft_pkg::STORE_BITS-1:0] wd0, wd1, ra0, rb0, ra1, rb1, rda, rdb;
  logic [r2fft_pkg::ADDR_BITS-1:0]  wa0, wa1;
  logic                             we;
  logic                             b_in_copy1;
  logic [POINTS_L-1:0]              live1;
  logic                             sel_a, sel_b;

  logic signed [D-1:0]  ar, ai, br, bi;
  logic signed [TB-1:0] wr, wi;
  logic signed [PB-1:0] pr, pi;
  logic signed [PB-1:0] rr, ri;
  logic signed [D-1:0]  tr, ti;
  logic signed [D-1:0]  sar, sai;

  // Loads go to both copies. A butterfly writes top into copy 0 and bottom
  // into copy 1 in the same cycle.
  always_comb begin
    we = cmd.load_we | cmd.wr_en;
    if (cmd.load_we) begin
      wa0 = cmd.load_addr;
      wa1 = cmd.load_addr;
      wd0 = {D'(sample), D'(0)};
      wd1 = {D'(sample), D'(0)};
    end else begin
      wa0 = cmd.wr_a;
      wa1 = cmd.wr_b;
      wd0 = {D'(sar + tr), D'(sai + ti)};
      wd1 = {D'(sar - tr), D'(sai - ti)};
    end
  end

  // live1 marks entries whose current value sits in copy 1; the select is
  // registered alongside the RAM read so it lines up with read data.
  always_ff @(posedge clk) begin
    if (cmd.load_we) live1[cmd.load_addr] <= 1'b0;
    if (cmd.wr_en) begin
      live1[cmd.wr_a] <= 1'b0;
      live1[cmd.wr_b] <= 1'b1;
    end
    if (cmd.rd_en) begin
      sel_a <= live1[cmd.rd_a];
      sel_b <= live1[cmd.rd_b];
    end
  end

  r2fft_ram #(.WIDTH(r2fft_pkg::STORE_BITS), .DEPTH(POINTS_L)) u_ram0 (
    .clk(clk), .we(we), .waddr(wa0), .wdata(wd0),
    .raddr_a(cmd.rd_a), .raddr_b(cmd.rd_b), .rdata_a(ra0), .rdata_b(rb0));
  r2fft_ram #(.WIDTH(r2fft_pkg::STORE_BITS), .DEPTH(POINTS_L)) u_ram1 (
    .clk(clk), .we(we), .waddr(wa1), .wdata(wd1),
    .raddr_a(cmd.rd_a), .raddr_b(cmd.rd_b), .rdata_a(ra1), .rdata_b(rb1));

  assign b_in_copy1 = sel_b;
  assign rda = sel_a ? ra1 : ra0;
  assign rdb = b_in_copy1 ? rb1 : rb0;

  always_comb begin
    {ar, ai} = rda;
    {br, bi} = rdb;
    {wr, wi} = r2fft_pkg::twiddle(cmd.tw_idx);
    rr = pr + PB'(1 << (r2fft_pkg::FRAC_BITS - 1));
    ri = pi + PB'(1 << (r2fft_pkg::FRAC_BITS - 1));
    tr = D'(rr >>> r2fft_pkg::FRAC_BITS);
    ti = D'(ri >>> r2fft_pkg::FRAC_BITS);
  end

  // product register, top operand held alongside
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      pr  <= PB'(br * wr) - PB'(bi * wi);
      pi  <= PB'(bi * wr) + PB'(br * wi);
      sar <= ar;
      sai <= ai;
    end
  end

  // unload: the pair addresses are held, so read data stays put while shown
  assign {even_real, even_imag} = rda;
  assign {odd_real, odd_imag}   = rdb;
endmodule

// ===== hdl/r2fft_ctrl.sv =====
// ----------------------------------------------------------------------------
// r2fft_ctrl
// Load counter, butterfly sequencer and unload sequencer.
// ----------------------------------------------------------------------------
module r2fft_ctrl (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  sample_valid,
  output logic                                  sample_ready,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic [r2fft_pkg::OUT_PAIR_BITS-1:0]   pair_index,
  output logic                                  last_pair,
  output r2fft_pkg::cmd_t                       cmd
);
  localparam int AB = r2fft_pkg::ADDR_BITS;
  localparam int PB = r2fft_pkg::PAIR_BITS;
  localparam int SB = r2fft_pkg::STAGE_BITS;

  r2fft_pkg::state_t state, state_next;
  logic [AB-1:0] load_count;
  logic [SB-1:0] stage;
  logic [PB-1:0] bfly;
  logic [PB-1:0] pair;
  logic          bfly_last, stage_last;
  logic [AB-1:0] top, bot, half;
  logic [6:0]    tw;

  assign half       = AB'(1) << stage;
  assign bfly_last  = bfly == PB'(r2fft_pkg::POINTS / 2 - 1);
  assign stage_last = stage == SB'(r2fft_pkg::STAGES - 1);
  assign sample_ready = state == r2fft_pkg::ST_LOAD;

  // top = insert a zero at bit 'stage' of the butterfly count
  // twiddle index = n * 128 / size = n << (6 - stage)
  always_comb begin
    logic [AB:0] lo_mask, wide;
    lo_mask = ((AB+1)'(1) << stage) - (AB+1)'(1);
    wide = (((AB+1)'(bfly) & ~lo_mask) << 1) | ((AB+1)'(bfly) & lo_mask);
    top  = wide[AB-1:0];
    bot  = top | half;
    tw   = 7'((8'(bfly) & 8'(lo_mask)) << (6 - stage));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= r2fft_pkg::ST_LOAD;
      load_count <= '0;
      stage <= '0;
      bfly <= '0;
      pair <= '0;
    end else begin
      state <= state_next;
      if (sample_valid && sample_ready) load_count <= load_count + AB'(1);
      if (state == r2fft_pkg::ST_WR) begin
        bfly <= bfly + PB'(1);
        if (bfly_last) stage <= stage + SB'(1);
      end
      if (state == r2fft_pkg::ST_LOAD) begin
        stage <= '0;
        bfly  <= '0;
        pair  <= '0;
      end
      if (state == r2fft_pkg::ST_OUT_HOLD && result_ready) pair <= pair + PB'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      r2fft_pkg::ST_LOAD:
        if (sample_valid && load_count == AB'(r2fft_pkg::POINTS - 1))
          state_next = r2fft_pkg::ST_RD;
      r2fft_pkg::ST_RD:  state_next = r2fft_pkg::ST_MUL;
      r2fft_pkg::ST_MUL: state_next = r2fft_pkg::ST_WR;
      r2fft_pkg::ST_WR:
        state_next = (bfly_last && stage_last) ? r2fft_pkg::ST_OUT_RD : r2fft_pkg::ST_RD;
      r2fft_pkg::ST_OUT_RD: state_next = r2fft_pkg::ST_OUT_HOLD;
      r2fft_pkg::ST_OUT_HOLD:
        if (result_ready)
          state_next = (pair == PB'(r2fft_pkg::POINTS / 2 - 1)) ? r2fft_pkg::ST_LOAD
                                                                  : r2fft_pkg::ST_OUT_RD;
      default: state_next = r2fft_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.load_addr = r2fft_pkg::bit_rev(load_count);
    cmd.tw_idx    = tw;
    cmd.wr_a      = top;
    cmd.wr_b      = bot;
    cmd.rd_a      = top;
    cmd.rd_b      = bot;
    result_valid  = 1'b0;
    unique case (state)
      r2fft_pkg::ST_LOAD:     cmd.load_we = sample_valid;
      r2fft_pkg::ST_RD:       cmd.rd_en = 1'b1;
      r2fft_pkg::ST_MUL:      cmd.mul_en = 1'b1;
      r2fft_pkg::ST_WR:       cmd.wr_en = 1'b1;
      r2fft_pkg::ST_OUT_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_a  = AB'({pair, 1'b0});
        cmd.rd_b  = AB'({pair, 1'b1});
      end
      // keep reading the same pair so the word holds until taken
      r2fft_pkg::ST_OUT_HOLD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_a     = AB'({pair, 1'b0});
        cmd.rd_b     = AB'({pair, 1'b1});
        result_valid = 1'b1;
      end
      default: ;
    endcase
  end

  assign pair_index = r2fft_pkg::OUT_PAIR_BITS'(pair);
  assign last_pair  = pair == PB'(r2fft_pkg::POINTS / 2 - 1);

`ifndef SYNTHESIS
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    state != r2fft_pkg::ST_LOAD |-> !result_valid || state == r2fft_pkg::ST_OUT_HOLD)
    else $error("result shown outside hold");
  a_mul_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == r2fft_pkg::ST_RD |=> state == r2fft_pkg::ST_MUL)
    else $error("read not followed by multiply");
  a_load_clear: assert property (@(posedge clk) disable iff (rst)
    $rose(state == r2fft_pkg::ST_LOAD) |-> load_count == '0)
    else $error("load count not wrapped");
`endif
endmodule

// ===== hdl/radix2_real_input_fft.sv =====
// ----------------------------------------------------------------------------
// radix2_real_input_fft
// 128-point real-input radix-2 DIT FFT, one shared butterfly, unscaled 24-bit.
// ----------------------------------------------------------------------------
// Load: one sample word per cycle while sample_valid is high, into bit-reversed store addresses.
// Transform: each butterfly steps through read, multiply and write states; 448 butterflies.
// Unload: 64 result words, each read in ST_OUT_RD and shown in ST_OUT_HOLD until taken.
// The first result word is shown once the last butterfly has been written.
// A new frame is taken only after the last result word of the previous one.
// Sync reset returns to loading with an empty frame; store contents undefined.
module radix2_real_input_fft (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_ready,
  input  logic signed [15:0] sample,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [5:0]  pair_index,
  output logic signed [23:0] even_real,
  output logic signed [23:0] even_imag,
  output logic signed [23:0] odd_real,
  output logic signed [23:0] odd_imag,
  output logic        last_pair
);
  r2fft_pkg::cmd_t cmd;

  // controller sequences load, butterflies and unload
  r2fft_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_ready(sample_ready),
    .result_valid(result_valid), .result_ready(result_ready),
    .pair_index(pair_index), .last_pair(last_pair), .cmd(cmd));

  // datapath: store, butterfly, output word straight from the store read
  r2fft_datapath u_dp (
    .clk(clk), .cmd(cmd), .sample(sample),
    .even_real(even_real), .even_imag(even_imag),
    .odd_real(odd_real), .odd_imag(odd_imag));
endmodule

// ===== bench/radix2_real_input_fft_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix2_real_input_fft_tb
// Drives a frame of real samples with random gaps, models the fixed-point FFT
// in the bench and checks every output word field by field, in order.
// ----------------------------------------------------------------------------
module radix2_real_input_fft_tb;

  localparam int POINTS    = r2fft_pkg::POINTS;
  localparam int FRAC_BITS = r2fft_pkg::FRAC_BITS;
  localparam int STAGES    = r2fft_pkg::STAGES;

  // one output word: bins 2p and 2p+1
  typedef struct packed {
    logic [5:0]         idx;
    logic signed [23:0] er;
    logic signed [23:0] ei;
    logic signed [23:0] orl;
    logic signed [23:0] oi;
    logic               last;
  } bin_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_ready;
  logic signed [15:0] sample = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [5:0] pair_index;
  logic signed [23:0] even_real, even_imag, odd_real, odd_imag;
  logic last_pair;

  always #1 clk = ~clk;

  radix2_real_input_fft u_top (
    .clk, .rst, .sample_valid, .sample_ready, .sample, .result_valid,
    .result_ready, .pair_index, .even_real, .even_imag, .odd_real,
    .odd_imag, .last_pair
  );

  // bench copy of the frame store
  logic signed [23:0] fft_re [POINTS];
  logic signed [23:0] fft_im [POINTS];
  int unsigned frame_fill = 0;
  bin_pair_t expected_bins[$];
  int errors = 0;
  int words_checked = 0;
  int frames_sent = 0;
  bit stim_done = 1'b0;

  // cosine table, units of 1e-9, quarter wave
  localparam longint unsigned COS_E9 [33] = '{
    1000000000, 998795456, 995184727, 989176510, 980785280, 970031253,
    956940336, 941544065, 923879533, 903989293, 881921264, 857728610,
    831469612, 803207531, 773010453, 740951125, 707106781, 671558955,
    634393284, 595699304, 555570233, 514102744, 471396737, 427555093,
    382683432, 336889853, 290284677, 242980180, 195090322, 146730474,
    98017140, 49067674, 0};

  function automatic longint tw_rom(int k);
    return longint'(((COS_E9[k] << FRAC_BITS) + 500000000) / 1000000000);
  endfunction

  // rounded to nearest, half up, then arithmetic shift (floor)
  function automatic longint round_q(longint v);
    return (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic int unsigned bitrev7(int unsigned v);
    int unsigned r;
    r = 0;
    for (int i = 0; i < STAGES; i++) r = (r << 1) | ((v >> i) & 1);
    return r;
  endfunction

  // store one sample; on the last of a frame run the transform and queue bins
  task automatic fft_accept(logic signed [15:0] s);
    int unsigned a, sz, hf, stp, tp, bt;
    longint wr, wi, c, sn, br, bi, tr, ti;
    bin_pair_t bp;
    a = bitrev7(frame_fill);
    fft_re[a] = 24'(s);
    fft_im[a] = '0;
    frame_fill++;
    if (frame_fill < POINTS) return;
    frame_fill = 0;
    frames_sent++;
    for (sz = 2; sz <= POINTS; sz <<= 1) begin
      hf = sz / 2;
      stp = 128 / sz;
      for (int b = 0; b < POINTS; b += sz)
        for (int n = 0; n < hf; n++) begin
          a = (n * stp) & 63;
          if (a <= 32) begin
            c = tw_rom(a); sn = tw_rom(32 - a);
          end else begin
            c = -tw_rom(64 - a); sn = tw_rom(a - 32);
          end
          // +1.0 cannot be held, so it saturates
          if (c > (longint'(1) << FRAC_BITS) - 1) c = (longint'(1) << FRAC_BITS) - 1;
          wr = c; wi = -sn;
          tp = b + n; bt = b + n + hf;
          br = fft_re[bt]; bi = fft_im[bt];
          tr = round_q(br * wr - bi * wi);
          ti = round_q(bi * wr + br * wi);
          fft_re[bt] = 24'(longint'(fft_re[tp]) - tr);
          fft_im[bt] = 24'(longint'(fft_im[tp]) - ti);
          fft_re[tp] = 24'(longint'(fft_re[tp]) + tr);
          fft_im[tp] = 24'(longint'(fft_im[tp]) + ti);
        end
    end
    for (int p = 0; p < POINTS / 2; p++) begin
      bp.idx = 6'(p);
      bp.er = fft_re[2*p]; bp.ei = fft_im[2*p];
      bp.orl = fft_re[2*p+1]; bp.oi = fft_im[2*p+1];
      bp.last = (p == POINTS / 2 - 1);
      expected_bins.push_back(bp);
    end
  endtask

  function automatic int gap_len();
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3);
    return $urandom_range(40);
  endfunction

  // valid drops only when a gap follows, so back-to-back words keep it high
  task automatic send_word(logic signed [15:0] s);
    int g;
    g = gap_len();
    if (g > 0) begin
      sample_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (!sample_ready);
    fft_accept(s);
  endtask

  // directed rows: extremes, zero, unit, sign patterns; remainder random
  localparam int DIR_ROWS = 8;
  localparam logic signed [15:0] DIR_TABLE [DIR_ROWS] = '{
    16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
    16'sh0001, 16'sh5555, 16'shAAAA, 16'sh7FFF};

  task automatic wait_drained();
    while (expected_bins.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // one frame: directed rows first, random fill after
    for (int i = 0; i < POINTS; i++)
      send_word(i < DIR_ROWS ? DIR_TABLE[i] : 16'($urandom));
    sample_valid <= 1'b0;
    wait_drained();   // sender holds off until all bins are back
    stim_done = 1'b1;
  end

  // output side: random stalls, mostly short with a few long ones; check in order
  initial begin
    bin_pair_t ex;
    int stall_left;
    stall_left = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (result_valid && result_ready) begin
        if (expected_bins.size() == 0) begin
          $display("%0t: unexpected word pair_index=%0d", $time, pair_index);
          errors++;
        end else begin
          ex = expected_bins.pop_front();
          words_checked++;
          if ({pair_index, even_real, even_imag, odd_real, odd_imag, last_pair} !== ex) begin
            $display("%0t: mismatch exp idx=%0d %0d %0d %0d %0d last=%0b", $time,
                     ex.idx, ex.er, ex.ei, ex.orl, ex.oi, ex.last);
            $display("%0t:          got idx=%0d %0d %0d %0d %0d last=%0b", $time,
                     pair_index, even_real, even_imag, odd_real, odd_imag, last_pair);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(29) == 0) begin
        result_ready <= 1'b0;
        stall_left = $urandom_range(40);
      end else begin
        result_ready <= ($urandom_range(9) < 7);
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Ran %0d frames of %0d samples; %0d bin-pair words checked.",
             frames_sent, POINTS, words_checked);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #200000;
    $display("Timeout with %0d words outstanding.", expected_bins.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
